/* rtl/pts_pkg.sv */
// Shared types and codes for the priority task scheduler queue.
`default_nettype none

package pts_pkg;

  localparam int ID_W    = 8;
  localparam int PRIO_W  = 4;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t item;
  } cell_ctrl_t;

  typedef struct packed {
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  wait_sum;
    logic [COUNT_W-1:0] served;
  } stats_t;

endpackage

`default_nettype wire

/* rtl/pts_cell.sv */
// One slot of the sorted task chain: holds, shifts or loads a task entry.
`default_nettype none

module pts_cell #(
  parameter int OCC_W = 6,
  parameter int INDEX = 0
) (
  input  wire                     clk,
  input  wire pts_pkg::cell_ctrl_t ctrl,
  input  wire [OCC_W-1:0]         occ,
  input  wire pts_pkg::entry_t    left_entry,
  input  wire                     left_keep,
  input  wire pts_pkg::entry_t    right_entry,
  output pts_pkg::entry_t         entry,
  output logic                    keep
);

  pts_pkg::entry_t entry_next;

  // A live slot stays ahead of the new task when its priority is not lower.
  assign keep = (occ > OCC_W'(INDEX)) && (entry.prio >= ctrl.item.prio);

  always_comb begin
    entry_next = entry;
    priority if (ctrl.ins) begin
      priority if (keep) begin
        entry_next = entry;
      end else if (left_keep) begin
        entry_next = ctrl.item;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.pop) begin
      entry_next = right_entry;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

/* rtl/pts_stats.sv */
// Elapsed time and saturating service totals of the scheduler.
`default_nettype none

module pts_stats (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           run,
  input  wire [pts_pkg::BURST_W-1:0]    burst,
  output pts_pkg::stats_t               stats,
  output pts_pkg::stats_t               stats_next
);

  logic [pts_pkg::TIME_W:0] finish_sum;
  logic [pts_pkg::TIME_W:0] turn_sum;
  logic [pts_pkg::TIME_W:0] wait_sum;
  logic [pts_pkg::TIME_W-1:0] finish;

  assign finish_sum = {1'b0, stats.elapsed}
                    + {{(pts_pkg::TIME_W + 1 - pts_pkg::BURST_W){1'b0}}, burst};
  assign finish     = finish_sum[pts_pkg::TIME_W] ? '1 : finish_sum[pts_pkg::TIME_W-1:0];
  assign turn_sum   = {1'b0, stats.turnaround} + {1'b0, finish};
  assign wait_sum   = {1'b0, stats.wait_sum} + {1'b0, stats.elapsed};

  always_comb begin
    stats_next = stats;
    if (run) begin
      stats_next.elapsed    = finish;
      stats_next.turnaround = turn_sum[pts_pkg::TIME_W] ? '1 : turn_sum[pts_pkg::TIME_W-1:0];
      stats_next.wait_sum   = wait_sum[pts_pkg::TIME_W] ? '1 : wait_sum[pts_pkg::TIME_W-1:0];
      if (stats.served != '1) begin
        stats_next.served = stats.served + pts_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else begin
      stats <= stats_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/priority_task_scheduler_queue.sv */
// Top level of the non-preemptive priority task scheduler queue.
`default_nettype none

// A command accepted at a clock edge has its result on the outputs, marked by
// done, during the next cycle, and a new command may be accepted at every edge
// (busy stays low). The task table is a chain of QUEUE_DEPTH cells kept sorted
// by descending priority, ties in arrival order; an insert shifts the cells
// behind its slot down by one, and a pop shifts the whole chain up by one.
// Results cannot be held off: done is high for exactly one cycle per command and
// the result must be taken then.
// Status 1 marks an insert refused by a full table, status 2 a pop on an empty one.
module priority_task_scheduler_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  output logic                           busy,
  input  wire                            kind,
  input  wire [pts_pkg::ID_W-1:0]        task_id,
  input  wire [pts_pkg::PRIO_W-1:0]      priority_req,
  input  wire [pts_pkg::BURST_W-1:0]     burst,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [pts_pkg::ID_W-1:0]       out_task_id,
  output logic [pts_pkg::PRIO_W-1:0]     out_priority,
  output logic [pts_pkg::BURST_W-1:0]    out_burst,
  output logic [pts_pkg::TIME_W-1:0]     start_time,
  output logic [pts_pkg::TIME_W-1:0]     finish_time,
  output logic [pts_pkg::TIME_W-1:0]     sum_turnaround,
  output logic [pts_pkg::TIME_W-1:0]     sum_wait,
  output logic [pts_pkg::COUNT_W-1:0]    served_count
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(QUEUE_DEPTH);

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [OCC_W-1:0]     occ;
  logic [OCC_W-1:0]     occ_next;
  pts_pkg::cell_ctrl_t  ctrl;
  pts_pkg::stats_t      stats;
  pts_pkg::stats_t      stats_next;
  pts_pkg::entry_t      head;
  pts_pkg::entry_t      cell_entry [QUEUE_DEPTH];
  logic                 cell_keep  [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (occ == DEPTH_OCC);
  assign empty  = (occ == '0);

  assign ctrl.ins        = accept && (kind == pts_pkg::KIND_INSERT) && !full;
  assign ctrl.pop        = accept && (kind == pts_pkg::KIND_POP) && !empty;
  assign ctrl.item.id    = task_id;
  assign ctrl.item.prio  = priority_req;
  assign ctrl.item.burst = burst;

  assign head = cell_entry[0];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pts_pkg::entry_t left_entry;
    pts_pkg::entry_t right_entry;
    logic            left_keep;

    if (i == 0) begin : g_first
      assign left_entry = ctrl.item;
      assign left_keep  = 1'b1;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    pts_cell #(
      .OCC_W (OCC_W),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ),
      .left_entry  (left_entry),
      .left_keep   (left_keep),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  pts_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .run        (ctrl.pop),
    .burst      (head.burst),
    .stats      (stats),
    .stats_next (stats_next)
  );

  always_comb begin
    priority if (ctrl.ins) begin
      occ_next = occ + OCC_W'(1);
    end else if (ctrl.pop) begin
      occ_next = occ - OCC_W'(1);
    end else begin
      occ_next = occ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      done <= 1'b0;
    end else begin
      occ  <= occ_next;
      done <= accept;
    end
  end

  // Result word, loaded at every accepted command.
  always_ff @(posedge clk) begin
    if (accept) begin
      sum_turnaround <= stats_next.turnaround;
      sum_wait       <= stats_next.wait_sum;
      served_count   <= stats_next.served;
      if (ctrl.pop) begin
        status       <= pts_pkg::ST_OK;
        out_task_id  <= head.id;
        out_priority <= head.prio;
        out_burst    <= head.burst;
        start_time   <= stats.elapsed;
        finish_time  <= stats_next.elapsed;
      end else begin
        out_task_id  <= '0;
        out_priority <= '0;
        out_burst    <= '0;
        start_time   <= '0;
        finish_time  <= '0;
        priority if (kind == pts_pkg::KIND_INSERT) begin
          status <= full ? pts_pkg::ST_FULL : pts_pkg::ST_OK;
        end else begin
          status <= pts_pkg::ST_EMPTY;
        end
      end
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= DEPTH_OCC)
    else $error("occupancy beyond table depth");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted command gave no result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == pts_pkg::ST_FULL) |-> (occ == DEPTH_OCC))
    else $error("full status with room in the table");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == pts_pkg::ST_EMPTY) |-> (occ == '0))
    else $error("empty status with tasks in the table");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the priority task scheduler queue.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pts_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int RANDOM_WORDS = 400;
  localparam int SOAK_PAIRS = 45;
  localparam int MAX_REPORTS = 10;
  localparam time WATCHDOG_NS = 4_800_000;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    task_id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  start_t;
    logic [TIME_W-1:0]  finish_t;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  wait_sum;
    logic [COUNT_W-1:0] served;
  } sched_result_t;

  class sched_scoreboard;
    entry_t        run_order[$];
    logic [31:0]   elapsed;
    logic [31:0]   turnaround;
    logic [31:0]   wait_sum;
    logic [15:0]   served;
    sched_result_t pending[$];
    int            mismatches;

    function new();
      elapsed = '0;
      turnaround = '0;
      wait_sum = '0;
      served = '0;
      mismatches = 0;
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Predict the result of one accepted word and queue it.
    function void note_command(logic k, entry_t e);
      sched_result_t r;
      entry_t        head;
      int            pos;
      r = '0;
      if (k == KIND_INSERT) begin
        if (run_order.size() >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // Place behind every task of equal or higher priority.
          pos = 0;
          while (pos < run_order.size() && run_order[pos].prio >= e.prio) pos++;
          run_order.insert(pos, e);
          r.status = ST_OK;
        end
      end else if (run_order.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        head = run_order.pop_front();
        r.status = ST_OK;
        r.task_id = head.id;
        r.prio = head.prio;
        r.burst = head.burst;
        r.start_t = elapsed;
        r.finish_t = sat_add(elapsed, {16'd0, head.burst});
        elapsed = r.finish_t;
        turnaround = sat_add(turnaround, r.finish_t);
        wait_sum = sat_add(wait_sum, r.start_t);
        if (served != 16'hFFFF) served++;
      end
      r.turnaround = turnaround;
      r.wait_sum = wait_sum;
      r.served = served;
      pending.push_back(r);
    endfunction

    function void report(string what, sched_result_t r);
      $display("  %s: status=%0d id=%0d prio=%0d burst=%0d start=%0d finish=%0d",
               what, r.status, r.task_id, r.prio, r.burst, r.start_t, r.finish_t);
      $display("  %s: sum_turnaround=%0d sum_wait=%0d served=%0d",
               what, r.turnaround, r.wait_sum, r.served);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] result with nothing outstanding", $realtime);
          report("actual", got);
        end
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status || got.task_id !== want.task_id ||
            got.prio !== want.prio || got.burst !== want.burst ||
            got.start_t !== want.start_t || got.finish_t !== want.finish_t ||
            got.turnaround !== want.turnaround || got.wait_sum !== want.wait_sum ||
            got.served !== want.served) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] result differs", $realtime);
            report("expected", want);
            report("actual", got);
          end
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic kind = KIND_INSERT;
  logic [ID_W-1:0] task_id = '0;
  logic [PRIO_W-1:0] priority_req = '0;
  logic [BURST_W-1:0] burst = '0;
  logic busy;
  logic done;
  logic [1:0] status;
  logic [ID_W-1:0] out_task_id;
  logic [PRIO_W-1:0] out_priority;
  logic [BURST_W-1:0] out_burst;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] finish_time;
  logic [TIME_W-1:0] sum_turnaround;
  logic [TIME_W-1:0] sum_wait;
  logic [COUNT_W-1:0] served_count;

  sched_scoreboard sched = new();

  int words_left = 0;
  int gap_limit = 6;

  always #2 clk = ~clk;

  priority_task_scheduler_queue #(
    .QUEUE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .task_id(task_id),
    .priority_req(priority_req),
    .burst(burst),
    .done(done),
    .status(status),
    .out_task_id(out_task_id),
    .out_priority(out_priority),
    .out_burst(out_burst),
    .start_time(start_time),
    .finish_time(finish_time),
    .sum_turnaround(sum_turnaround),
    .sum_wait(sum_wait),
    .served_count(served_count)
  );

  // Check the result of the previous word before noting the one taken now.
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) begin
        sched.check_result('{status, out_task_id, out_priority, out_burst, start_time,
                             finish_time, sum_turnaround, sum_wait, served_count});
      end
      if (start === 1'b1 && busy === 1'b0) begin
        sched.note_command(kind, '{task_id, priority_req, burst});
      end
    end
  end

  // Send one word; open a new burst after a random gap when the last one ran out.
  task automatic issue(logic k, logic [ID_W-1:0] id, logic [PRIO_W-1:0] p,
                       logic [BURST_W-1:0] b);
    int gap;
    if (words_left == 0) begin
      words_left = $urandom_range(1, 24);
      gap = $urandom_range(0, gap_limit);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    words_left--;
    start <= 1'b1;
    kind <= k;
    task_id <= id;
    priority_req <= p;
    burst <= b;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pop_task();
    issue(KIND_POP, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
          16'($urandom_range(0, 65535)));
  endtask

  initial begin
    int ins_pct;
    int lo_prio;
    int hi_prio;
    logic [BURST_W-1:0] b;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pop, field extremes, ties among equals, drain past empty.
    pop_task();
    issue(KIND_INSERT, 8'd0, 4'd0, 16'd0);
    issue(KIND_INSERT, 8'd255, 4'd15, 16'hFFFF);
    issue(KIND_INSERT, 8'd1, 4'd7, 16'h5555);
    issue(KIND_INSERT, 8'd2, 4'd7, 16'hAAAA);
    issue(KIND_INSERT, 8'd3, 4'd7, 16'h0001);
    issue(KIND_INSERT, 8'd4, 4'd15, 16'h8000);
    issue(KIND_INSERT, 8'hAA, 4'd0, 16'h00FF);
    repeat (8) pop_task();
    pop_task();

    // Random: phases biased towards filling, churning or draining the table.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 90;
          1: ins_pct = 50;
          default: ins_pct = 15;
        endcase
        if (n == 0) ins_pct = 95;
        gap_limit = ($urandom_range(0, 2) == 0) ? 0 : 6;
        lo_prio = $urandom_range(0, 15);
        hi_prio = ($urandom_range(0, 1) == 0) ? lo_prio + 1 : 15;
        if (hi_prio > 15) hi_prio = 15;
        if (lo_prio > hi_prio) lo_prio = 0;
      end
      if ($urandom_range(0, 99) < ins_pct) begin
        issue(KIND_INSERT, 8'($urandom_range(0, 255)), 4'($urandom_range(lo_prio, hi_prio)),
              16'($urandom_range(0, 65535)));
      end else begin
        pop_task();
      end
    end

    // Run of long tasks: push the elapsed time and the time sums up quickly.
    gap_limit = 2;
    for (int n = 0; n < SOAK_PAIRS; n++) begin
      b = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 65535)) : 16'hFFFF;
      issue(KIND_INSERT, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), b);
      pop_task();
    end
    repeat (3) pop_task();

    start <= 1'b0;
    while (sched.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sched.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
